### rtl/booth_radix2_signed_multiplier_assert.svh
// Assertion macros used by the Booth multiplier top level.
// No dependencies; included by the files that carry assertions.
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_ASSERT_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BRSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BRSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/brsm_pkg.sv
// Widths, Booth codes and the per-stage state type of the Booth multiplier.
// No dependencies; used by the interfaces, the stage and the top level.
package brsm_pkg;

   localparam int MULTIPLICAND_WIDTH = 16;
   localparam int MULTIPLIER_WIDTH   = 16;
   // One guard bit keeps the most negative multiplicand exact.
   localparam int ACC_WIDTH          = MULTIPLICAND_WIDTH + 1;
   localparam int PRODUCT_WIDTH      = MULTIPLICAND_WIDTH + MULTIPLIER_WIDTH;
   localparam int STAGE_COUNT        = MULTIPLIER_WIDTH;

   // Booth recoding of {current bit, previous bit}.
   localparam logic [1:0] BOOTH_ADD = 2'b01;
   localparam logic [1:0] BOOTH_SUB = 2'b10;

   typedef struct packed {
      logic [ACC_WIDTH-1:0]        acc;
      logic [MULTIPLIER_WIDTH-1:0] q;
      logic                        prev;
      logic [ACC_WIDTH-1:0]        mcand;
   } brsm_state_type;

endpackage

### rtl/brsm_req_if.sv
// Operand channel of the Booth multiplier: valid, ready and both operands.
// Depends on brsm_pkg.
interface brsm_req_if;
   import brsm_pkg::*;

   logic                                 valid;
   logic                                 ready;
   logic signed [MULTIPLICAND_WIDTH-1:0] multiplicand;
   logic signed [MULTIPLIER_WIDTH-1:0]   multiplier;

   modport source (output valid, output multiplicand, output multiplier, input ready);
   modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

### rtl/brsm_rsp_if.sv
// Product channel of the Booth multiplier: valid, ready and the product.
// Depends on brsm_pkg.
interface brsm_rsp_if;
   import brsm_pkg::*;

   logic                            valid;
   logic                            ready;
   logic signed [PRODUCT_WIDTH-1:0] product;

   modport source (output valid, output product, input ready);
   modport sink   (input valid, input product, output ready);
endinterface

### rtl/brsm_stage.sv
// One pipeline stage of the Booth multiplier: a single recoding step and its register.
// Depends on brsm_pkg.
module brsm_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  brsm_pkg::brsm_state_type in_state,
   output logic                    out_valid,
   input  logic                    out_ready,
   output brsm_pkg::brsm_state_type out_state
);
   import brsm_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   brsm_state_type       state_ff;
   brsm_state_type       state_in;
   logic [ACC_WIDTH-1:0] sum;

   always_comb begin
      case ({in_state.q[0], in_state.prev})
         BOOTH_SUB: sum = in_state.acc - in_state.mcand;
         BOOTH_ADD: sum = in_state.acc + in_state.mcand;
         default:   sum = in_state.acc;
      endcase
      // Arithmetic right shift across the accumulator and multiplier register.
      state_in.acc   = {sum[ACC_WIDTH-1], sum[ACC_WIDTH-1:1]};
      state_in.q     = {sum[0], in_state.q[MULTIPLIER_WIDTH-1:1]};
      state_in.prev  = in_state.q[0];
      state_in.mcand = in_state.mcand;
   end

   // The stage takes a transfer when it is empty or its contents move on.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_ready) begin
         valid_in = in_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

### rtl/booth_radix2_signed_multiplier.sv
// Top level of the pipelined radix-2 Booth signed multiplier.
// Depends on brsm_pkg, brsm_req_if, brsm_rsp_if, brsm_stage and the assertion header.
//
//   Channel   Direction   Payload                      Role
//   req_if    in          multiplicand, multiplier     operand pair, 16 + 16 bits signed
//   rsp_if    out         product                      exact product, 32 bits signed
//
// One Booth step per register stage, MULTIPLIER_WIDTH (16) stages in a row.
// A new operand pair is taken every cycle while the pipeline is not stalled; the product
// passes through every stage register in turn and appears on rsp_if after the last one.
// Reset clears every stage's valid bit; the operand and accumulator registers keep no reset.
// Under a stall, ready ripples back: a stage takes a transfer when it is empty or
// when its successor takes its contents, so bubbles are squeezed out and nothing is lost.
`include "booth_radix2_signed_multiplier_assert.svh"

module booth_radix2_signed_multiplier (
   input logic        clock,
   input logic        reset,
   brsm_req_if.sink   req_if,
   brsm_rsp_if.source rsp_if
);
   import brsm_pkg::*;

   logic           stage_valid [0:STAGE_COUNT];
   logic           stage_ready [0:STAGE_COUNT];
   brsm_state_type stage_state [0:STAGE_COUNT];

   // Initial Booth state: empty accumulator, multiplier loaded, previous bit zero.
   assign stage_valid[0]       = req_if.valid;
   assign req_if.ready         = stage_ready[0];
   assign stage_state[0].acc   = '0;
   assign stage_state[0].q     = req_if.multiplier;
   assign stage_state[0].prev  = 1'b0;
   assign stage_state[0].mcand = {req_if.multiplicand[MULTIPLICAND_WIDTH-1],
                                  req_if.multiplicand};

   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      brsm_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_state  (stage_state[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_state (stage_state[k+1])
      );

      `BRSM_ASSERT_NEXT(a_mcand_carried, clock, reset,
         stage_valid[k] && stage_ready[k],
         stage_state[k+1].mcand == $past(stage_state[k].mcand),
         "multiplicand changed between stages")
   end

   // The guard bit is dropped: the product fits the low bits of the accumulator.
   assign rsp_if.valid               = stage_valid[STAGE_COUNT];
   assign stage_ready[STAGE_COUNT]   = rsp_if.ready;
   assign rsp_if.product = {stage_state[STAGE_COUNT].acc[MULTIPLICAND_WIDTH-1:0],
                            stage_state[STAGE_COUNT].q};

   `BRSM_ASSERT_IMPL(a_full_when_blocked, clock, reset,
      !req_if.ready,
      stage_valid[1] && stage_valid[STAGE_COUNT],
      "operand channel blocked with an empty stage")
   `BRSM_ASSERT_IMPL(a_guard_bit, clock, reset,
      rsp_if.valid,
      stage_state[STAGE_COUNT].acc[ACC_WIDTH-1] == stage_state[STAGE_COUNT].acc[ACC_WIDTH-2],
      "product overflowed the guard bit")
   `BRSM_ASSERT_IMPL(a_zero_mcand, clock, reset,
      rsp_if.valid && (stage_state[STAGE_COUNT].mcand == '0),
      rsp_if.product == '0,
      "zero multiplicand gave a nonzero product")

endmodule
